// ===== rtl/core/rshe_pkg.sv =====
// ----------------------------------------------------------------------------
// Spherical harmonic evaluator package
// Shape codes, the control word passed down the pipeline, and fixed constants.
// ----------------------------------------------------------------------------
package rshe_pkg;

  localparam int QBITS = 15;
  localparam int CW    = 17;

  localparam logic [15:0]   VAL_S   = 16'd9243;
  localparam logic [CW-1:0] C_P     = 17'd32021;
  localparam logic [CW-1:0] C_D15   = 17'd71601;
  localparam logic [CW-1:0] C_DZ2   = 17'd20670;
  localparam logic [CW-1:0] C_DX2Y2 = 17'd35801;

  typedef enum logic [3:0] {
    SH_S      = 4'd0,
    SH_PX     = 4'd1,
    SH_PY     = 4'd2,
    SH_PZ     = 4'd3,
    SH_DXY    = 4'd4,
    SH_DYZ    = 4'd5,
    SH_DZ2    = 4'd6,
    SH_DXZ    = 4'd7,
    SH_DX2MY2 = 4'd8
  } shape_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] op;
    logic       neg;
    logic       zero;
    logic       pmode;
  } ctl_t;

endpackage

// ===== rtl/core/real_spherical_harmonic_eval.sv =====
// ----------------------------------------------------------------------------
// Real spherical harmonic evaluator, degrees zero to two
// Returns the angular function of a selected shape for a 3-D vector in Q1.15.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start_i is high and busy_o is low.
// busy_o stays low, so a new request may be issued in every cycle.
// Each request gives exactly one result: valid_o is high for one cycle with
// value_o and zero_radius_o, and the result is taken at the end of that cycle.
// Results come out in request order.
// Five front stages form the magnitudes, squares, numerator and the
// comparison bound with split multipliers; a chain of 15 cells then decides
// one quotient bit each, and a last stage applies the sign and the shape.
// Throughput is one request per cycle.
// Reset clears every valid flag in the pipeline; requests in flight are lost.
// The receiver cannot stall the block.
// ----------------------------------------------------------------------------
module real_spherical_harmonic_eval #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [3:0]                       op_i,
  input  logic signed [COMPONENT_BITS-1:0] kx_i,
  input  logic signed [COMPONENT_BITS-1:0] ky_i,
  input  logic signed [COMPONENT_BITS-1:0] kz_i,
  output logic                             valid_o,
  output logic signed [15:0]               value_o,
  output logic                             zero_radius_o
);
  import rshe_pkg::*;

  localparam int CB   = COMPONENT_BITS;
  localparam int RW   = 2 * CB + 2 * CW;
  localparam int AW   = RW + 1;
  localparam int R2W  = 2 * CB + 2;
  localparam int LINW = R2W + QBITS;

  ctl_t            ctl_s [QBITS+1];
  logic [RW-1:0]   rhs_s [QBITS+1];
  logic [R2W-1:0]  r2_s  [QBITS+1];
  logic [AW-1:0]   acc_s [QBITS+1];
  logic [LINW-1:0] lin_s [QBITS+1];
  logic [QBITS-1:0] q_s  [QBITS+1];

  ctl_t fin;
  logic [15:0] val_d, val_q;
  logic valid_q, zero_q;

  rshe_front #(.CB(CB)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .kx_i    (kx_i),
    .ky_i    (ky_i),
    .kz_i    (kz_i),
    .ctl_o   (ctl_s[0]),
    .rhs_o   (rhs_s[0]),
    .r2_o    (r2_s[0])
  );

  assign acc_s[0] = '0;
  assign lin_s[0] = '0;
  assign q_s[0]   = '0;

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    rshe_cell #(.CB(CB), .BIT(QBITS - 1 - i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[i]),
      .rhs_i  (rhs_s[i]),
      .r2_i   (r2_s[i]),
      .acc_i  (acc_s[i]),
      .lin_i  (lin_s[i]),
      .q_i    (q_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .rhs_o  (rhs_s[i+1]),
      .r2_o   (r2_s[i+1]),
      .acc_o  (acc_s[i+1]),
      .lin_o  (lin_s[i+1]),
      .q_o    (q_s[i+1])
    );
  end

  assign fin = ctl_s[QBITS];

  always_comb begin
    val_d = '0;
    case (fin.op) inside
      SH_S: val_d = VAL_S;
      SH_PX, SH_PY, SH_PZ, SH_DXY, SH_DYZ, SH_DZ2, SH_DXZ, SH_DX2MY2: begin
        if (!fin.zero) begin
          val_d = fin.neg ? (16'd0 - 16'(q_s[QBITS])) : 16'(q_s[QBITS]);
        end
      end
      default: val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    zero_q <= fin.zero;
  end

  assign busy_o        = 1'b0;
  assign valid_o       = valid_q;
  assign value_o       = val_q;
  assign zero_radius_o = zero_q;

endmodule

// ===== rtl/core/rshe_front.sv =====
// ----------------------------------------------------------------------------
// Spherical harmonic front end
// Magnitudes, squares, numerator and the right-hand side of the quotient test.
// ----------------------------------------------------------------------------
module rshe_front #(
  parameter int CB = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [3:0]             op_i,
  input  logic signed [CB-1:0]   kx_i,
  input  logic signed [CB-1:0]   ky_i,
  input  logic signed [CB-1:0]   kz_i,
  output rshe_pkg::ctl_t         ctl_o,
  output logic [2*CB+2*rshe_pkg::CW-1:0] rhs_o,
  output logic [2*CB+1:0]        r2_o
);
  import rshe_pkg::*;

  localparam int R2W = 2 * CB + 2;
  localparam int NH  = CB + 1;
  localparam int W   = CB + CW;
  localparam int H   = (W + 1) / 2;
  localparam int HW  = W - H;
  localparam int RW  = 2 * CB + 2 * CW;

  ctl_t c1_q, c1_d, c2_q, c2_d, c3_q, c3_d, c4_q, c5_q;
  logic [CB-1:0] mx_q, my_q, mz_q, mx_d, my_d, mz_d;
  logic sx_q, sy_q, sz_q;
  logic [2*CB-1:0] x2_q, y2_q, z2_q, pr_q, pr_d;
  logic [CB-1:0] pa, pb, pm;
  logic [W-1:0] cm_q, cm_d, cm3_q;
  logic [R2W-1:0] r2_q, r2_d, r2_4_q, n_q, n_d;
  logic [CW-1:0] cc_q, cc_d;
  logic [2*CB:0] da, db;
  logic [CW+NH-1:0] pd_lo_q, pd_hi_q;
  logic [2*HW-1:0] hh_q;
  logic [HW+H-1:0] hl_q;
  logic [2*H-1:0] ll_q;
  logic [RW-1:0] rhs_d, rhs_q;
  logic [R2W-1:0] r2_5_q;

  always_comb begin
    mx_d = kx_i[CB-1] ? (CB'(0) - $unsigned(kx_i)) : $unsigned(kx_i);
    my_d = ky_i[CB-1] ? (CB'(0) - $unsigned(ky_i)) : $unsigned(ky_i);
    mz_d = kz_i[CB-1] ? (CB'(0) - $unsigned(kz_i)) : $unsigned(kz_i);
    c1_d = '{valid: start_i, op: op_i, neg: 1'b0, zero: 1'b0, pmode: 1'b0};
  end

  always_comb begin
    c2_d = c1_q;
    c2_d.zero = ((mx_q | my_q | mz_q) == '0);
    pa = '0;
    pb = '0;
    pm = '0;
    case (c1_q.op)
      SH_PX: begin
        pm = mx_q; c2_d.neg = sx_q; c2_d.pmode = 1'b1;
      end
      SH_PY: begin
        pm = my_q; c2_d.neg = sy_q; c2_d.pmode = 1'b1;
      end
      SH_PZ: begin
        pm = mz_q; c2_d.neg = sz_q; c2_d.pmode = 1'b1;
      end
      SH_DXY: begin
        pa = mx_q; pb = my_q; c2_d.neg = sx_q ^ sy_q;
      end
      SH_DYZ: begin
        pa = mz_q; pb = my_q; c2_d.neg = sz_q ^ sy_q;
      end
      SH_DXZ: begin
        pa = mz_q; pb = mx_q; c2_d.neg = sz_q ^ sx_q;
      end
      default: ;
    endcase
    pr_d = (2*CB)'(pa) * (2*CB)'(pb);
    cm_d = W'(C_P) * W'(pm);
  end

  always_comb begin
    c3_d = c2_q;
    r2_d = R2W'(x2_q) + R2W'(y2_q) + R2W'(z2_q);
    da = '0;
    db = '0;
    n_d = R2W'(pr_q);
    cc_d = C_D15;
    case (c2_q.op)
      SH_DZ2: begin
        da = {z2_q, 1'b0};
        db = (2*CB+1)'(x2_q) + (2*CB+1)'(y2_q);
        cc_d = C_DZ2;
      end
      SH_DX2MY2: begin
        da = (2*CB+1)'(x2_q);
        db = (2*CB+1)'(y2_q);
        cc_d = C_DX2Y2;
      end
      default: ;
    endcase
    if (c2_q.op == SH_DZ2 || c2_q.op == SH_DX2MY2) begin
      c3_d.neg = (da < db);
      n_d = (da < db) ? R2W'(db - da) : R2W'(da - db);
    end
  end

  always_comb begin
    if (c4_q.pmode) begin
      rhs_d = (RW'(hh_q) << (2 * H)) + (RW'(hl_q) << (H + 1)) + RW'(ll_q);
    end else begin
      rhs_d = (RW'(pd_hi_q) << NH) + RW'(pd_lo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else begin
      c1_q <= c1_d;
      c2_q <= c2_d;
      c3_q <= c3_d;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;
    my_q <= my_d;
    mz_q <= mz_d;
    sx_q <= kx_i[CB-1];
    sy_q <= ky_i[CB-1];
    sz_q <= kz_i[CB-1];
    x2_q <= (2*CB)'(mx_q) * (2*CB)'(mx_q);
    y2_q <= (2*CB)'(my_q) * (2*CB)'(my_q);
    z2_q <= (2*CB)'(mz_q) * (2*CB)'(mz_q);
    pr_q <= pr_d;
    cm_q <= cm_d;
    r2_q <= r2_d;
    n_q <= n_d;
    cc_q <= cc_d;
    cm3_q <= cm_q;
    r2_4_q <= r2_q;
    pd_lo_q <= (CW+NH)'(cc_q) * (CW+NH)'(n_q[NH-1:0]);
    pd_hi_q <= (CW+NH)'(cc_q) * (CW+NH)'(n_q[R2W-1:NH]);
    hh_q <= (2*HW)'(cm3_q[W-1:H]) * (2*HW)'(cm3_q[W-1:H]);
    hl_q <= (HW+H)'(cm3_q[W-1:H]) * (HW+H)'(cm3_q[H-1:0]);
    ll_q <= (2*H)'(cm3_q[H-1:0]) * (2*H)'(cm3_q[H-1:0]);
    rhs_q <= rhs_d;
    r2_5_q <= r2_4_q;
  end

  assign ctl_o = c5_q;
  assign rhs_o = rhs_q;
  assign r2_o  = r2_5_q;

endmodule

// ===== rtl/core/rshe_cell.sv =====
// ----------------------------------------------------------------------------
// Spherical harmonic quotient cell
// Decides one quotient bit by a trial test and passes the item on.
// ----------------------------------------------------------------------------
module rshe_cell #(
  parameter int CB  = 16,
  parameter int BIT = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rshe_pkg::ctl_t                     ctl_i,
  input  logic [2*CB+2*rshe_pkg::CW-1:0]     rhs_i,
  input  logic [2*CB+1:0]                    r2_i,
  input  logic [2*CB+2*rshe_pkg::CW:0]       acc_i,
  input  logic [2*CB+2+rshe_pkg::QBITS-1:0]  lin_i,
  input  logic [rshe_pkg::QBITS-1:0]         q_i,
  output rshe_pkg::ctl_t                     ctl_o,
  output logic [2*CB+2*rshe_pkg::CW-1:0]     rhs_o,
  output logic [2*CB+1:0]                    r2_o,
  output logic [2*CB+2*rshe_pkg::CW:0]       acc_o,
  output logic [2*CB+2+rshe_pkg::QBITS-1:0]  lin_o,
  output logic [rshe_pkg::QBITS-1:0]         q_o
);
  import rshe_pkg::*;

  localparam int RW   = 2 * CB + 2 * CW;
  localparam int AW   = RW + 1;
  localparam int LINW = 2 * CB + 2 + QBITS;

  logic [AW-1:0] t_p, t_d, acc_d;
  logic [AW+1:0] lhs;
  logic fit;
  logic [LINW-1:0] lin_d;
  logic [QBITS-1:0] q_d;
  ctl_t ctl_q;
  logic [RW-1:0] rhs_q;
  logic [2*CB+1:0] r2_q;
  logic [AW-1:0] acc_q;
  logic [LINW-1:0] lin_q;
  logic [QBITS-1:0] q_q;

  always_comb begin
    t_p = acc_i + (AW'(lin_i) << (BIT + 1)) + (AW'(r2_i) << (2 * BIT));
    t_d = acc_i + (AW'(r2_i) << BIT);
    lhs = ctl_i.pmode ? {t_p, 2'b00} : {1'b0, t_d, 1'b0};
    fit = (lhs <= (AW+2)'(rhs_i));
    acc_d = acc_i;
    lin_d = lin_i;
    q_d = q_i;
    if (fit) begin
      acc_d = ctl_i.pmode ? t_p : t_d;
      lin_d = lin_i + (LINW'(r2_i) << BIT);
      q_d = q_i | (QBITS'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rhs_q <= rhs_i;
    r2_q <= r2_i;
    acc_q <= acc_d;
    lin_q <= lin_d;
    q_q <= q_d;
  end

  assign ctl_o = ctl_q;
  assign rhs_o = rhs_q;
  assign r2_o  = r2_q;
  assign acc_o = acc_q;
  assign lin_o = lin_q;
  assign q_o   = q_q;

endmodule

// ===== tb/real_spherical_harmonic_eval_tb.sv =====
// ----------------------------------------------------------------------------
// Spherical harmonic evaluator testbench
// Sends shape requests in random bursts and predicts each Q1.15 result with an
// exact bitwise quotient search. Results are checked in order, field by field.
// ----------------------------------------------------------------------------
module real_spherical_harmonic_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rshe_pkg::*;

  typedef struct {
    logic [3:0]          op;
    logic signed [15:0]  kx;
    logic signed [15:0]  ky;
    logic signed [15:0]  kz;
    bit                  drain;
  } request_t;

  typedef struct {
    logic signed [15:0] value;
    logic               zero_radius;
  } harmonic_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [3:0]         op_i = '0;
  logic signed [15:0] kx_i = '0;
  logic signed [15:0] ky_i = '0;
  logic signed [15:0] kz_i = '0;
  logic               valid_o;
  logic signed [15:0] value_o;
  logic               zero_radius_o;

  request_t  pending_requests[$];
  harmonic_t expected_harmonics[$];
  int        mismatches = 0;
  int        requests_sent = 0;
  int        results_checked = 0;
  int        zero_vectors = 0;
  int        burst_left = 5;
  int        gap_left = 0;
  int        quiet_cycles = 0;

  real_spherical_harmonic_eval dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .op_i(op_i), .kx_i(kx_i), .ky_i(ky_i), .kz_i(kz_i),
    .valid_o(valid_o), .value_o(value_o), .zero_radius_o(zero_radius_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint magnitude(input logic signed [15:0] v);
    longint s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic int p_quotient(input longint m, input longint r2);
    logic [127:0] t;
    logic [127:0] bound;
    logic [127:0] c;
    int q;
    q = 0;
    t = (128'(C_P) * m) << 15;
    bound = t * t;
    for (int b = 14; b >= 0; b--) begin
      c = 128'(q | (1 << b));
      if (((c * c * r2) << 32) <= bound) q = q | (1 << b);
    end
    return q;
  endfunction

  function automatic int d_quotient(input longint cq, input longint n, input longint r2);
    logic [127:0] bound;
    logic [127:0] c;
    int q;
    q = 0;
    bound = 128'(cq) * n;
    for (int b = 14; b >= 0; b--) begin
      c = 128'(q | (1 << b));
      if (((c * r2) << 1) <= bound) q = q | (1 << b);
    end
    return q;
  endfunction

  function automatic harmonic_t predict_harmonic(input request_t r);
    harmonic_t h;
    longint mx, my, mz, x2, y2, z2, r2, n;
    bit neg;
    int q;
    mx = magnitude(r.kx);
    my = magnitude(r.ky);
    mz = magnitude(r.kz);
    x2 = mx * mx;
    y2 = my * my;
    z2 = mz * mz;
    r2 = x2 + y2 + z2;
    neg = 1'b0;
    q = 0;
    if (shape_e'(r.op) == SH_S) begin
      q = VAL_S;
    end else if (r2 != 0) begin
      case (shape_e'(r.op))
        SH_PX: begin q = p_quotient(mx, r2); neg = r.kx[15]; end
        SH_PY: begin q = p_quotient(my, r2); neg = r.ky[15]; end
        SH_PZ: begin q = p_quotient(mz, r2); neg = r.kz[15]; end
        SH_DXY: begin q = d_quotient(C_D15, mx * my, r2); neg = r.kx[15] ^ r.ky[15]; end
        SH_DYZ: begin q = d_quotient(C_D15, mz * my, r2); neg = r.kz[15] ^ r.ky[15]; end
        SH_DXZ: begin q = d_quotient(C_D15, mz * mx, r2); neg = r.kz[15] ^ r.kx[15]; end
        SH_DZ2: begin
          n = 2 * z2 - (x2 + y2);
          neg = n < 0;
          q = d_quotient(C_DZ2, neg ? -n : n, r2);
        end
        SH_DX2MY2: begin
          n = x2 - y2;
          neg = n < 0;
          q = d_quotient(C_DX2Y2, neg ? -n : n, r2);
        end
        default: q = 0;
      endcase
    end
    if (q > 32767) q = 32767;
    h.value = neg ? -16'(q) : 16'(q);
    h.zero_radius = (r2 == 0);
    return h;
  endfunction

  function automatic logic signed [15:0] random_component(input int style);
    case (style)
      0: return '0;
      1: return 16'($urandom_range(0, 15)) - 16'sd8;
      2: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_request(input int op, input int x, input int y, input int z,
                               input bit drain);
    request_t r;
    r.op = 4'(op);
    r.kx = 16'(x);
    r.ky = 16'(y);
    r.kz = 16'(z);
    r.drain = drain;
    pending_requests = {pending_requests, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    request_t taken;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        taken = pending_requests.pop_front();
        expected_harmonics = {expected_harmonics, predict_harmonic(taken)};
        requests_sent++;
        if (taken.kx == 0 && taken.ky == 0 && taken.kz == 0) zero_vectors++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_requests.size() > 0 && pending_requests[0].drain &&
                   expected_harmonics.size() > 0) begin
        start_i <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        pending_requests[0].drain = 1'b0;
        start_i <= 1'b1;
        op_i <= pending_requests[0].op;
        kx_i <= pending_requests[0].kx;
        ky_i <= pending_requests[0].ky;
        kz_i <= pending_requests[0].kz;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    harmonic_t want;
    if (rst_ni && valid_o) begin
      if (expected_harmonics.size() == 0) begin
        $display("%0t: unexpected result value=%0d zero_radius=%0b",
                 $time, value_o, zero_radius_o);
        mismatches++;
      end else begin
        want = expected_harmonics.pop_front();
        results_checked++;
        if (value_o !== want.value) begin
          $display("%0t: value expected %0d actual %0d", $time, want.value, value_o);
          mismatches++;
        end
        if (zero_radius_o !== want.zero_radius) begin
          $display("%0t: zero_radius expected %0b actual %0b",
                   $time, want.zero_radius, zero_radius_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 4000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int style;
    for (int op = 0; op <= 8; op++) queue_request(op, 0, 0, 0, 1'b0);
    for (int op = 0; op <= 8; op++) queue_request(op, -32768, -32768, -32768, 1'b0);
    queue_request(9, 32767, 0, 0, 1'b0);
    queue_request(15, 0, 0, 0, 1'b0);
    queue_request(SH_PX, -32768, 0, 0, 1'b0);
    queue_request(SH_PZ, 0, 0, 32767, 1'b0);
    queue_request(SH_DZ2, 1, 1, 0, 1'b0);
    queue_request(SH_DX2MY2, 1, -1, 0, 1'b0);
    for (int i = 0; i < 750; i++) begin
      style = $urandom_range(0, 9);
      queue_request($urandom_range(0, 9) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 8),
                    random_component(style < 6 ? 3 : $urandom_range(0, 3)),
                    random_component(style < 6 ? 3 : $urandom_range(0, 3)),
                    random_component(style < 6 ? 3 : $urandom_range(0, 3)),
                    (i % 150) == 149);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_requests.size() > 0 || expected_harmonics.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d requests (%0d zero vectors), checked %0d results.",
             requests_sent, zero_vectors, results_checked);
    $display("Covered all shapes, unused selectors and extreme components.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rshe_pkg.sv
rtl/core/rshe_front.sv
rtl/core/rshe_cell.sv
rtl/core/real_spherical_harmonic_eval.sv
tb/real_spherical_harmonic_eval_tb.sv
